// ----- hdl/tks_pkg.sv -----
// Shared types and constants for the token scanner.
`timescale 1ns / 1ps

package tks_pkg;

    // Scanner mode: pending operator or keyword prefix, comment or string.
    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_EQ,
        MODE_BANG,
        MODE_LT,
        MODE_GT,
        MODE_S,
        MODE_SA,
        MODE_COMMENT,
        MODE_STRING
    } mode_t;

    // Token kinds in enumeration order.
    localparam logic [5:0] KIND_LEFT_PAREN    = 6'd0;
    localparam logic [5:0] KIND_RIGHT_PAREN   = 6'd1;
    localparam logic [5:0] KIND_LEFT_BRACE    = 6'd2;
    localparam logic [5:0] KIND_RIGHT_BRACE   = 6'd3;
    localparam logic [5:0] KIND_COMMA         = 6'd4;
    localparam logic [5:0] KIND_DOT           = 6'd5;
    localparam logic [5:0] KIND_MINUS         = 6'd6;
    localparam logic [5:0] KIND_PLUS          = 6'd7;
    localparam logic [5:0] KIND_SEMICOLON     = 6'd8;
    localparam logic [5:0] KIND_F_SLASH       = 6'd9;
    localparam logic [5:0] KIND_STAR          = 6'd11;
    localparam logic [5:0] KIND_LEFT_SBRACE   = 6'd14;
    localparam logic [5:0] KIND_RIGHT_SBRACE  = 6'd15;
    localparam logic [5:0] KIND_RETURNS       = 6'd16;
    localparam logic [5:0] KIND_NOT_EQUAL     = 6'd18;
    localparam logic [5:0] KIND_EQUAL         = 6'd19;
    localparam logic [5:0] KIND_EQUAL_EQUAL   = 6'd20;
    localparam logic [5:0] KIND_GREATER       = 6'd21;
    localparam logic [5:0] KIND_GREATER_EQUAL = 6'd22;
    localparam logic [5:0] KIND_LESS          = 6'd23;
    localparam logic [5:0] KIND_LESS_EQUAL    = 6'd24;
    localparam logic [5:0] KIND_STRING        = 6'd28;
    localparam logic [5:0] KIND_SAY           = 6'd47;
    localparam logic [5:0] KIND_NONE          = 6'd0;

    // Source characters the scanner recognizes.
    localparam logic [7:0] CHAR_LPAREN    = 8'h28;
    localparam logic [7:0] CHAR_RPAREN    = 8'h29;
    localparam logic [7:0] CHAR_LBRACE    = 8'h7B;
    localparam logic [7:0] CHAR_RBRACE    = 8'h7D;
    localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
    localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
    localparam logic [7:0] CHAR_COMMA     = 8'h2C;
    localparam logic [7:0] CHAR_DOT       = 8'h2E;
    localparam logic [7:0] CHAR_MINUS     = 8'h2D;
    localparam logic [7:0] CHAR_PLUS      = 8'h2B;
    localparam logic [7:0] CHAR_SEMICOLON = 8'h3B;
    localparam logic [7:0] CHAR_STAR      = 8'h2A;
    localparam logic [7:0] CHAR_SLASH     = 8'h2F;
    localparam logic [7:0] CHAR_EQUAL     = 8'h3D;
    localparam logic [7:0] CHAR_GREATER   = 8'h3E;
    localparam logic [7:0] CHAR_LESS      = 8'h3C;
    localparam logic [7:0] CHAR_BANG      = 8'h21;
    localparam logic [7:0] CHAR_BACKTICK  = 8'h60;
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_UPPER_S   = 8'h53;
    localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Y   = 8'h59;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_CR        = 8'h0D;

    // Result queue geometry.
    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_PTR_BITS = 3;
    localparam int QUEUE_CNT_BITS = 4;

    // One token as it leaves the block.
    typedef struct packed {
        logic [5:0]  kind;
        logic        is_error;
        logic [15:0] start_pos;
        logic [15:0] lexeme_length;
        logic [15:0] line_number;
        logic        last;
    } tks_result_t;

    // Tokens produced by one source byte, handed to the result queue.
    typedef struct packed {
        logic [1:0]  count;
        tks_result_t slot1;
        tks_result_t slot0;
    } tks_push_t;

endpackage

// ----- hdl/token_scanner.sv -----
// Top level of the streaming token scanner.
`timescale 1ns / 1ps
//
// The slave channel carries one source byte per transfer in s_tdata; s_tlast
// marks the final byte of a text and flushes any pending token after it.
// The master channel carries one token per transfer: kind and error flag in
// m_tuser, start position, length and line number in m_tdata. m_tlast is set
// on the last token caused by one source byte; a byte causes zero, one or
// two tokens.
// A byte accepted at one clock edge is registered and scanned in the next
// cycle. Its tokens are written into the result queue at the end of that
// cycle and leave on the master side behind any tokens already queued. The
// scanner takes one byte per cycle as long as the master side keeps pace; a
// byte that yields two tokens hands them out one per transfer, and the
// eight-entry result queue absorbs the extra token.
// When the receiver stalls, tokens collect in the result queue and s_tready
// drops once the queue could not hold the tokens of the bytes in flight.
// Reset holds s_tready low, empties the queue, returns the scanner to idle,
// sets the byte position to zero and the line count to one. Positions wrap
// at POSITION_BITS and only reset restarts them.
//
module token_scanner #(
    parameter int POSITION_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // start_pos, lexeme_length, line_number
    output logic [6:0]  m_tuser,   // token_kind, is_error
    output logic        m_tlast    // last_of_run
);
    import tks_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        in_last_reg;
    logic        s_accept;
    logic [3:0]  fill;
    tks_push_t   push;
    tks_result_t head;

    // Leave room for two tokens from the byte in the register and two more.
    assign s_tready = aresetn && (in_valid_reg ? (fill <= 4'(QUEUE_DEPTH - 4))
                                               : (fill <= 4'(QUEUE_DEPTH - 2)));
    assign s_accept = s_tvalid && s_tready;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    tks_core #(
        .POSITION_BITS(POSITION_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_valid (in_valid_reg),
        .step_char  (in_char_reg),
        .step_last  (in_last_reg),
        .push       (push)
    );

    tks_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (head),
        .fill      (fill)
    );

    // Output packing.
    assign m_tdata = {head.line_number, head.lexeme_length, head.start_pos};
    assign m_tuser = {head.is_error, head.kind};
    assign m_tlast = head.last;

endmodule

// ----- hdl/tks_core.sv -----
// Scanner state and the per-byte token logic.
`timescale 1ns / 1ps

module tks_core #(
    parameter int POSITION_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_valid,
    input  logic [7:0]         step_char,
    input  logic               step_last,
    output tks_pkg::tks_push_t push
);
    import tks_pkg::*;

    mode_t                    mode_reg, mode_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [15:0]              line_reg, line_next;

    function automatic tks_result_t make_result(
        input logic [5:0]  kind,
        input logic        err,
        input logic [15:0] start,
        input logic [15:0] len,
        input logic [15:0] line
    );
        tks_result_t r;
        r.kind          = err ? KIND_NONE : kind;
        r.is_error      = err;
        r.start_pos     = start;
        r.lexeme_length = len;
        r.line_number   = line;
        r.last          = 1'b0;
        return r;
    endfunction

    // Resolve the pending prefix, rescan the byte if it was not used, then flush on end of text.
    always_comb begin
        tks_result_t              res [2];
        logic [1:0]               n;
        logic                     used;
        logic                     emit;
        logic [5:0]               e_kind;
        logic                     e_err;
        logic [15:0]              e_len;
        logic [POSITION_BITS-1:0] e_start;
        logic [POSITION_BITS-1:0] str_len;

        res[0]     = '0;
        res[1]     = '0;
        n          = 2'd0;
        used       = 1'b1;
        mode_next  = MODE_IDLE;
        start_next = start_reg;
        line_next  = line_reg;
        str_len    = pos_reg - start_reg;
        e_start    = '0;

        // Resolution of the mode left by the previous byte.
        emit    = 1'b0;
        e_kind  = KIND_NONE;
        e_err   = 1'b0;
        e_len   = 16'd1;
        case (mode_reg)
            MODE_EQ: begin
                emit = 1'b1;
                if (step_char == CHAR_GREATER) begin
                    e_kind = KIND_RETURNS;
                    e_len  = 16'd2;
                end else if (step_char == CHAR_EQUAL) begin
                    e_kind = KIND_EQUAL_EQUAL;
                    e_len  = 16'd2;
                end else begin
                    e_kind = KIND_EQUAL;
                    used   = 1'b0;
                end
            end
            MODE_BANG: begin
                emit = 1'b1;
                if (step_char == CHAR_EQUAL) begin
                    e_kind = KIND_NOT_EQUAL;
                    e_len  = 16'd2;
                end else begin
                    e_err = 1'b1;
                    used  = 1'b0;
                end
            end
            MODE_LT: begin
                emit = 1'b1;
                if (step_char == CHAR_EQUAL) begin
                    e_kind = KIND_LESS_EQUAL;
                    e_len  = 16'd2;
                end else begin
                    e_kind = KIND_LESS;
                    used   = 1'b0;
                end
            end
            MODE_GT: begin
                emit = 1'b1;
                if (step_char == CHAR_EQUAL) begin
                    e_kind = KIND_GREATER_EQUAL;
                    e_len  = 16'd2;
                end else begin
                    e_kind = KIND_GREATER;
                    used   = 1'b0;
                end
            end
            MODE_S: begin
                if (step_char == CHAR_UPPER_A) begin
                    mode_next = MODE_SA;
                end else begin
                    emit  = 1'b1;
                    e_err = 1'b1;
                    used  = 1'b0;
                end
            end
            MODE_SA: begin
                emit = 1'b1;
                if (step_char == CHAR_UPPER_Y) begin
                    e_kind = KIND_SAY;
                    e_len  = 16'd3;
                end else begin
                    e_err = 1'b1;
                    e_len = 16'd2;
                    used  = 1'b0;
                end
            end
            MODE_COMMENT: begin
                if (step_char == CHAR_NEWLINE) begin
                    line_next = line_reg + 16'd1;
                end
                if (step_char != CHAR_BACKTICK) begin
                    mode_next = MODE_COMMENT;
                end
            end
            MODE_STRING: begin
                if (step_char == CHAR_QUOTE) begin
                    emit   = 1'b1;
                    e_kind = KIND_STRING;
                    e_len  = 16'(str_len);
                end else begin
                    if (step_char == CHAR_NEWLINE) begin
                        line_next = line_reg + 16'd1;
                    end
                    mode_next = MODE_STRING;
                end
            end
            default: begin
                used = 1'b0;
            end
        endcase
        if (emit) begin
            res[0] = make_result(e_kind, e_err, 16'(start_reg), e_len, line_reg);
            n      = 2'd1;
        end

        // Fresh scan of a byte that the pending prefix did not take.
        if (!used) begin
            emit   = 1'b1;
            e_kind = KIND_NONE;
            e_err  = 1'b0;
            case (step_char)
                CHAR_LPAREN:    e_kind = KIND_LEFT_PAREN;
                CHAR_RPAREN:    e_kind = KIND_RIGHT_PAREN;
                CHAR_LBRACE:    e_kind = KIND_LEFT_BRACE;
                CHAR_RBRACE:    e_kind = KIND_RIGHT_BRACE;
                CHAR_LBRACKET:  e_kind = KIND_LEFT_SBRACE;
                CHAR_RBRACKET:  e_kind = KIND_RIGHT_SBRACE;
                CHAR_COMMA:     e_kind = KIND_COMMA;
                CHAR_DOT:       e_kind = KIND_DOT;
                CHAR_MINUS:     e_kind = KIND_MINUS;
                CHAR_PLUS:      e_kind = KIND_PLUS;
                CHAR_SEMICOLON: e_kind = KIND_SEMICOLON;
                CHAR_STAR:      e_kind = KIND_STAR;
                CHAR_SLASH:     e_kind = KIND_F_SLASH;
                CHAR_EQUAL: begin
                    emit = 1'b0; mode_next = MODE_EQ; start_next = pos_reg;
                end
                CHAR_BANG: begin
                    emit = 1'b0; mode_next = MODE_BANG; start_next = pos_reg;
                end
                CHAR_LESS: begin
                    emit = 1'b0; mode_next = MODE_LT; start_next = pos_reg;
                end
                CHAR_GREATER: begin
                    emit = 1'b0; mode_next = MODE_GT; start_next = pos_reg;
                end
                CHAR_UPPER_S: begin
                    emit = 1'b0; mode_next = MODE_S; start_next = pos_reg;
                end
                CHAR_SPACE, CHAR_CR, CHAR_TAB: begin
                    emit = 1'b0;
                end
                CHAR_NEWLINE: begin
                    emit      = 1'b0;
                    line_next = line_reg + 16'd1;
                end
                CHAR_BACKTICK: begin
                    emit = 1'b0; mode_next = MODE_COMMENT;
                end
                CHAR_QUOTE: begin
                    emit       = 1'b0;
                    mode_next  = MODE_STRING;
                    start_next = pos_reg + 1'b1;
                end
                default: e_err = 1'b1;
            endcase
            if (emit) begin
                res[n[0]] = make_result(e_kind, e_err, 16'(pos_reg), 16'd1, line_next);
                n         = n + 2'd1;
            end
        end

        // End of text flushes whatever token is still pending.
        if (step_last) begin
            emit    = 1'b1;
            e_kind  = KIND_NONE;
            e_err   = 1'b0;
            e_len   = 16'd1;
            e_start = pos_reg + 1'b1 - start_next;
            case (mode_next)
                MODE_EQ:   e_kind = KIND_EQUAL;
                MODE_BANG: e_err  = 1'b1;
                MODE_LT:   e_kind = KIND_LESS;
                MODE_GT:   e_kind = KIND_GREATER;
                MODE_S:    e_err  = 1'b1;
                MODE_SA: begin
                    e_err = 1'b1;
                    e_len = 16'd2;
                end
                MODE_STRING: begin
                    e_kind = KIND_STRING;
                    e_len  = 16'(e_start);
                end
                default: emit = 1'b0;
            endcase
            if (emit) begin
                res[n[0]] = make_result(e_kind, e_err, 16'(start_next), e_len, line_next);
                n         = n + 2'd1;
            end
            mode_next = MODE_IDLE;
        end

        // Mark the final token of this byte.
        if (n == 2'd1) begin
            res[0].last = 1'b1;
        end else if (n == 2'd2) begin
            res[1].last = 1'b1;
        end

        pos_next   = pos_reg + 1'b1;
        push.count = step_valid ? n : 2'd0;
        push.slot0 = res[0];
        push.slot1 = res[1];
    end

    // Scanner state advances once per processed byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            line_reg  <= 16'd1;
        end else if (step_valid) begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            line_reg  <= line_next;
        end
    end

endmodule

// ----- hdl/tks_fifo.sv -----
// Result queue that takes up to two tokens per cycle and releases one while out_ready is high.
`timescale 1ns / 1ps

module tks_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tks_pkg::tks_push_t   push,
    input  logic                 out_ready,
    output logic                 out_valid,
    output tks_pkg::tks_result_t out_data,
    output logic [3:0]           fill
);
    import tks_pkg::*;

    tks_result_t               mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0] count_reg, count_next;
    logic                      pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign fill      = count_reg;
    assign pop       = out_valid && out_ready;

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg + QUEUE_PTR_BITS'(push.count);
        rd_ptr_next = rd_ptr_reg + QUEUE_PTR_BITS'(pop);
        count_next  = count_reg + QUEUE_CNT_BITS'(push.count) - QUEUE_CNT_BITS'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage writes; the second token goes one entry after the first.
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.slot0;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_reg + 1'b1] <= push.slot1;
        end
    end

endmodule

// ----- hdl/tks_checker.sv -----
// Port-level checks for the token scanner and their binding.
`timescale 1ns / 1ps

module tks_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [6:0]  m_tuser,
    input logic        m_tlast
);
    import tks_pkg::*;

    // An offered byte waits unchanged until its transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
        else $error("offered byte changed before its transfer");

    // A stalled token holds its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled token changed");

    // Reset leaves no token on the master side.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("token present after reset");

    // Error tokens carry a zero kind.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[6] |-> m_tuser[5:0] == KIND_NONE)
        else $error("error token with nonzero kind");

    // Every token other than a string is one to three bytes long.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[6] || m_tuser[5:0] != KIND_STRING)
        |-> m_tdata[31:16] == 16'd1 || m_tdata[31:16] == 16'd2 || m_tdata[31:16] == 16'd3)
        else $error("token length out of range");

endmodule

bind token_scanner tks_checker u_tks_checker (.*);

// ----- tb/sv/tks_token_checker.sv -----
// Token predictor and result checker that watches both streams of the token scanner.
`timescale 1ns / 1ps

module tks_token_checker
    import tks_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_byte
    input  logic        s_tlast,   // end_of_text
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // start_pos, lexeme_length, line_number
    input  logic [6:0]  m_tuser,   // token_kind, is_error
    input  logic        m_tlast,   // last_of_run
    output int          mismatch_count,
    output int          tokens_pending
);

    // Keep the log readable when the block is badly off.
    localparam int PRINT_LIMIT = 50;

    // Predicted scanner state.
    mode_t       scan_mode;
    logic [15:0] byte_pos;
    logic [15:0] lexeme_start;
    logic [15:0] line_count;

    // Tokens caused by the byte being scanned, and tokens still owed by the block.
    tks_result_t step_tok [2];
    int          step_n;
    tks_result_t expected_tokens [$];

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("MISMATCH at %0t: %s, got %0d, expected %0d", $time, what, got_v, want_v);
        end
        mismatch_count++;
    endtask

    // Append one token to the tail of the expectation queue.
    task automatic enqueue_expected(input tks_result_t tok);
        expected_tokens.insert(expected_tokens.size(), tok);
    endtask

    task automatic add_token(input logic [5:0] kind, input logic err,
                             input logic [15:0] start, input logic [15:0] len);
        tks_result_t tok;
        tok.kind          = kind;
        tok.is_error      = err;
        tok.start_pos     = start;
        tok.lexeme_length = len;
        tok.line_number   = line_count;
        tok.last          = 1'b0;
        step_tok[step_n]  = tok;
        step_n++;
    endtask

    // A byte seen with no prefix pending.
    task automatic scan_fresh(input logic [7:0] ch, input logic [15:0] pos);
        case (ch)
            CHAR_LPAREN:    add_token(KIND_LEFT_PAREN, 1'b0, pos, 16'd1);
            CHAR_RPAREN:    add_token(KIND_RIGHT_PAREN, 1'b0, pos, 16'd1);
            CHAR_LBRACE:    add_token(KIND_LEFT_BRACE, 1'b0, pos, 16'd1);
            CHAR_RBRACE:    add_token(KIND_RIGHT_BRACE, 1'b0, pos, 16'd1);
            CHAR_LBRACKET:  add_token(KIND_LEFT_SBRACE, 1'b0, pos, 16'd1);
            CHAR_RBRACKET:  add_token(KIND_RIGHT_SBRACE, 1'b0, pos, 16'd1);
            CHAR_COMMA:     add_token(KIND_COMMA, 1'b0, pos, 16'd1);
            CHAR_DOT:       add_token(KIND_DOT, 1'b0, pos, 16'd1);
            CHAR_MINUS:     add_token(KIND_MINUS, 1'b0, pos, 16'd1);
            CHAR_PLUS:      add_token(KIND_PLUS, 1'b0, pos, 16'd1);
            CHAR_SEMICOLON: add_token(KIND_SEMICOLON, 1'b0, pos, 16'd1);
            CHAR_STAR:      add_token(KIND_STAR, 1'b0, pos, 16'd1);
            CHAR_SLASH:     add_token(KIND_F_SLASH, 1'b0, pos, 16'd1);
            CHAR_EQUAL: begin
                scan_mode = MODE_EQ;
                lexeme_start = pos;
            end
            CHAR_BANG: begin
                scan_mode = MODE_BANG;
                lexeme_start = pos;
            end
            CHAR_LESS: begin
                scan_mode = MODE_LT;
                lexeme_start = pos;
            end
            CHAR_GREATER: begin
                scan_mode = MODE_GT;
                lexeme_start = pos;
            end
            CHAR_UPPER_S: begin
                scan_mode = MODE_S;
                lexeme_start = pos;
            end
            CHAR_SPACE, CHAR_CR, CHAR_TAB: ;
            CHAR_NEWLINE:   line_count = line_count + 16'd1;
            CHAR_BACKTICK:  scan_mode = MODE_COMMENT;
            CHAR_QUOTE: begin
                // The string lexeme starts after the opening quote.
                scan_mode = MODE_STRING;
                lexeme_start = pos + 16'd1;
            end
            default:        add_token(KIND_NONE, 1'b1, pos, 16'd1);
        endcase
    endtask

    // Work out the tokens one accepted byte causes and queue them.
    task automatic predict_tokens(input logic [7:0] ch, input logic eot);
        mode_t       prior;
        logic [15:0] pos;
        logic        consumed;
        pos      = byte_pos;
        prior    = scan_mode;
        scan_mode = MODE_IDLE;
        consumed = 1'b1;
        step_n   = 0;

        // Resolve a pending prefix; a byte that does not complete it is scanned anew.
        case (prior)
            MODE_EQ: begin
                if (ch == CHAR_GREATER) begin
                    add_token(KIND_RETURNS, 1'b0, lexeme_start, 16'd2);
                end else if (ch == CHAR_EQUAL) begin
                    add_token(KIND_EQUAL_EQUAL, 1'b0, lexeme_start, 16'd2);
                end else begin
                    add_token(KIND_EQUAL, 1'b0, lexeme_start, 16'd1);
                    consumed = 1'b0;
                end
            end
            MODE_BANG: begin
                if (ch == CHAR_EQUAL) begin
                    add_token(KIND_NOT_EQUAL, 1'b0, lexeme_start, 16'd2);
                end else begin
                    add_token(KIND_NONE, 1'b1, lexeme_start, 16'd1);
                    consumed = 1'b0;
                end
            end
            MODE_LT: begin
                if (ch == CHAR_EQUAL) begin
                    add_token(KIND_LESS_EQUAL, 1'b0, lexeme_start, 16'd2);
                end else begin
                    add_token(KIND_LESS, 1'b0, lexeme_start, 16'd1);
                    consumed = 1'b0;
                end
            end
            MODE_GT: begin
                if (ch == CHAR_EQUAL) begin
                    add_token(KIND_GREATER_EQUAL, 1'b0, lexeme_start, 16'd2);
                end else begin
                    add_token(KIND_GREATER, 1'b0, lexeme_start, 16'd1);
                    consumed = 1'b0;
                end
            end
            MODE_S: begin
                if (ch == CHAR_UPPER_A) begin
                    scan_mode = MODE_SA;
                end else begin
                    add_token(KIND_NONE, 1'b1, lexeme_start, 16'd1);
                    consumed = 1'b0;
                end
            end
            MODE_SA: begin
                if (ch == CHAR_UPPER_Y) begin
                    add_token(KIND_SAY, 1'b0, lexeme_start, 16'd3);
                end else begin
                    add_token(KIND_NONE, 1'b1, lexeme_start, 16'd2);
                    consumed = 1'b0;
                end
            end
            MODE_COMMENT: begin
                if (ch == CHAR_NEWLINE) line_count = line_count + 16'd1;
                if (ch != CHAR_BACKTICK) scan_mode = MODE_COMMENT;
            end
            MODE_STRING: begin
                if (ch == CHAR_QUOTE) begin
                    add_token(KIND_STRING, 1'b0, lexeme_start, pos - lexeme_start);
                end else begin
                    if (ch == CHAR_NEWLINE) line_count = line_count + 16'd1;
                    scan_mode = MODE_STRING;
                end
            end
            default: consumed = 1'b0;
        endcase
        if (!consumed) scan_fresh(ch, pos);

        // End of text flushes whatever is still pending; a comment just ends.
        if (eot) begin
            case (scan_mode)
                MODE_EQ:     add_token(KIND_EQUAL, 1'b0, lexeme_start, 16'd1);
                MODE_BANG:   add_token(KIND_NONE, 1'b1, lexeme_start, 16'd1);
                MODE_LT:     add_token(KIND_LESS, 1'b0, lexeme_start, 16'd1);
                MODE_GT:     add_token(KIND_GREATER, 1'b0, lexeme_start, 16'd1);
                MODE_S:      add_token(KIND_NONE, 1'b1, lexeme_start, 16'd1);
                MODE_SA:     add_token(KIND_NONE, 1'b1, lexeme_start, 16'd2);
                MODE_STRING: add_token(KIND_STRING, 1'b0, lexeme_start,
                                       pos + 16'd1 - lexeme_start);
                default: ;
            endcase
            scan_mode = MODE_IDLE;
        end

        byte_pos = pos + 16'd1;
        if (step_n > 0) step_tok[step_n - 1].last = 1'b1;
        for (int i = 0; i < step_n; i++) enqueue_expected(step_tok[i]);
    endtask

    // Compare one token transfer with the oldest expectation.
    task automatic check_token();
        tks_result_t want;
        if (expected_tokens.size() == 0) begin
            report_mismatch("token with nothing expected, start_pos", m_tdata[15:0], 0);
            return;
        end
        want = expected_tokens.pop_front();
        if (m_tuser[5:0] !== want.kind)
            report_mismatch("token_kind", m_tuser[5:0], want.kind);
        if (m_tuser[6] !== want.is_error)
            report_mismatch("is_error", m_tuser[6], want.is_error);
        if (m_tdata[15:0] !== want.start_pos)
            report_mismatch("start_pos", m_tdata[15:0], want.start_pos);
        if (m_tdata[31:16] !== want.lexeme_length)
            report_mismatch("lexeme_length", m_tdata[31:16], want.lexeme_length);
        if (m_tdata[47:32] !== want.line_number)
            report_mismatch("line_number", m_tdata[47:32], want.line_number);
        if (m_tlast !== want.last)
            report_mismatch("last_of_run", m_tlast, want.last);
    endtask

    // Sample both channels at each rising edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            scan_mode    = MODE_IDLE;
            byte_pos     = 16'd0;
            lexeme_start = 16'd0;
            line_count   = 16'd1;
            expected_tokens.delete();
        end else begin
            if (s_tvalid && s_tready) predict_tokens(s_tdata, s_tlast);
            if (m_tvalid && m_tready) check_token();
        end
        tokens_pending <= expected_tokens.size();
    end

endmodule

// ----- tb/sv/tb.sv -----
// Testbench top for the token scanner: clock, reset, source text stimulus and verdict.
`timescale 1ns / 1ps

module tb;
    import tks_pkg::*;

    localparam int ITEM_TARGET    = 1850;
    localparam int PHASE_ITEMS    = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    // Bytes the scanner treats as errors, used in the directed text.
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_LOWER_A   = 8'h61;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [6:0]  m_tuser;
    logic        m_tlast;

    int mismatch_count;
    int tokens_pending;
    int byte_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    always #5 aclk = ~aclk;

    token_scanner dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    tks_token_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .tokens_pending (tokens_pending)
    );

    // Receiver stalls at random at the current rate.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Count cycles in which neither channel moves a transfer.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: the run is stuck if nothing moves for too long.
    initial begin
        wait (aresetn);
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("== FAIL ==");
        $finish;
    end

    // Offer one byte, after a random idle gap, and hold it until the transfer.
    task automatic send_byte(input logic [7:0] ch, input logic eot);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= eot;
        do @(posedge aclk); while (!s_tready);
        byte_count++;
    endtask

    function automatic logic rand_end();
        return $urandom_range(39) == 0;
    endfunction

    // One piece of source text: mostly well-formed lexemes, some noise.
    task automatic send_piece();
        int          choice;
        int          n;
        logic [7:0]  lead;
        choice = $urandom_range(9);
        case (choice)
            0, 1, 2: begin
                case ($urandom_range(12))
                    0:  lead = CHAR_LPAREN;
                    1:  lead = CHAR_RPAREN;
                    2:  lead = CHAR_LBRACE;
                    3:  lead = CHAR_RBRACE;
                    4:  lead = CHAR_LBRACKET;
                    5:  lead = CHAR_RBRACKET;
                    6:  lead = CHAR_COMMA;
                    7:  lead = CHAR_DOT;
                    8:  lead = CHAR_MINUS;
                    9:  lead = CHAR_PLUS;
                    10: lead = CHAR_SEMICOLON;
                    11: lead = CHAR_STAR;
                    default: lead = CHAR_SLASH;
                endcase
                send_byte(lead, rand_end());
            end
            3, 4: begin
                // Operator prefix; only the first choice completes it.
                case ($urandom_range(3))
                    0:       lead = CHAR_EQUAL;
                    1:       lead = CHAR_BANG;
                    2:       lead = CHAR_LESS;
                    default: lead = CHAR_GREATER;
                endcase
                send_byte(lead, rand_end());
                if (choice == 3) begin
                    send_byte((lead == CHAR_EQUAL && $urandom_range(1) == 1) ?
                              CHAR_GREATER : CHAR_EQUAL, rand_end());
                end
            end
            5: begin
                // The keyword, or a prefix of it.
                n = ($urandom_range(4) < 3) ? 3 : $urandom_range(2, 1);
                send_byte(CHAR_UPPER_S, rand_end());
                if (n > 1) send_byte(CHAR_UPPER_A, rand_end());
                if (n > 2) send_byte(CHAR_UPPER_Y, rand_end());
            end
            6, 7: begin
                // String or comment with random body, sometimes left open.
                lead = (choice == 6) ? CHAR_QUOTE : CHAR_BACKTICK;
                send_byte(lead, rand_end());
                n = $urandom_range(6);
                repeat (n) begin
                    send_byte(($urandom_range(3) == 0) ? CHAR_NEWLINE : 8'($urandom_range(255)),
                              rand_end());
                end
                if ($urandom_range(4) != 0) send_byte(lead, rand_end());
            end
            8: begin
                case ($urandom_range(3))
                    0:       lead = CHAR_SPACE;
                    1:       lead = CHAR_TAB;
                    2:       lead = CHAR_CR;
                    default: lead = CHAR_NEWLINE;
                endcase
                send_byte(lead, rand_end());
            end
            default: send_byte(8'($urandom_range(255)), rand_end());
        endcase
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed text: byte extremes, the operators =>, =, !=, <, <= and >, keyword
        // prefixes, strings and comments across lines, and flushes at end of text.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CHAR_EQUAL, 1'b0);
        send_byte(CHAR_GREATER, 1'b0);
        send_byte(CHAR_EQUAL, 1'b0);
        send_byte(CHAR_BANG, 1'b0);
        send_byte(CHAR_EQUAL, 1'b0);
        send_byte(CHAR_LESS, 1'b0);
        send_byte(CHAR_LESS, 1'b0);
        send_byte(CHAR_EQUAL, 1'b0);
        send_byte(CHAR_GREATER, 1'b0);
        send_byte(CHAR_UPPER_S, 1'b0);
        send_byte(CHAR_UPPER_A, 1'b0);
        send_byte(CHAR_BACKSLASH, 1'b0);
        send_byte(CHAR_UPPER_S, 1'b0);
        send_byte(CHAR_QUOTE, 1'b0);
        send_byte(CHAR_NEWLINE, 1'b0);
        send_byte(CHAR_QUOTE, 1'b0);
        send_byte(CHAR_BACKTICK, 1'b0);
        send_byte(CHAR_NEWLINE, 1'b0);
        send_byte(CHAR_BACKTICK, 1'b0);
        send_byte(CHAR_BANG, 1'b0);
        send_byte(CHAR_TAB, 1'b0);
        send_byte(CHAR_UPPER_S, 1'b0);
        send_byte(CHAR_UPPER_A, 1'b0);
        send_byte(CHAR_UPPER_Y, 1'b0);
        send_byte(CHAR_GREATER, 1'b1);
        send_byte(CHAR_QUOTE, 1'b0);
        send_byte(CHAR_LOWER_A, 1'b1);

        // Random text, rotating through the idling phases.
        while (byte_count < ITEM_TARGET) begin
            case ((byte_count / PHASE_ITEMS) % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 51;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 51;
                end
                default: begin
                    send_idle_pct  = 12;
                    recv_stall_pct = 12;
                end
            endcase
            send_piece();
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        @(posedge aclk);

        // Let the remaining tokens drain, then watch for strays.
        while (tokens_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && tokens_pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/tks_pkg.sv
hdl/tks_core.sv
hdl/tks_fifo.sv
hdl/token_scanner.sv
hdl/tks_checker.sv
tb/sv/tks_token_checker.sv
tb/sv/tb.sv
